// ===== sv/non_maximum_suppression_defines.svh =====
// Assertion macros shared by the non-maximum suppression RTL.
`ifndef NON_MAXIMUM_SUPPRESSION_DEFINES_SVH
`define NON_MAXIMUM_SUPPRESSION_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NMS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define NMS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/nms_pkg.sv =====
// Shared types, constants and the direction binning function.
package nms_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int CFG_DATA_W     = 13;
  localparam int FRAME_WIDTH_RESET  = 1024;
  localparam int FRAME_HEIGHT_RESET = 1024;

  localparam int MAG_W      = 16;
  localparam int PHASE_W    = 15;
  localparam int BIN_W      = 2;
  localparam int S_TDATA_W  = 32;
  localparam int M_TDATA_W  = 24;

  // Q3.12 angle constants: pi and the bin bounds pi/8, 3pi/8, 5pi/8, 7pi/8
  localparam logic signed [PHASE_W:0] PI_Q12  = 16'sd12868;
  localparam logic signed [PHASE_W:0] BOUND_1 = 16'sd1608;
  localparam logic signed [PHASE_W:0] BOUND_2 = 16'sd4825;
  localparam logic signed [PHASE_W:0] BOUND_3 = 16'sd8042;
  localparam logic signed [PHASE_W:0] BOUND_4 = 16'sd11259;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [BIN_W-1:0] {
    DIR_HORIZONTAL      = 2'd0,
    DIR_DIAG_DOWN_RIGHT = 2'd1,
    DIR_VERTICAL        = 2'd2,
    DIR_DIAG_DOWN_LEFT  = 2'd3
  } dir_t;

  typedef logic [MAG_W-1:0] mag_t;

  // One window column: [0] upper row, [1] centre row, [2] lower row
  typedef logic [2:0][MAG_W-1:0] column_t;

  // Line buffer word: both magnitude rows and the centre row phase
  typedef struct packed {
    mag_t               upper;
    mag_t               centre;
    logic [PHASE_W-1:0] phase;
  } line_word_t;

  localparam int LINE_WORD_W = $bits(line_word_t);

  // Fold negative angles by pi, then bin against the four bounds
  function automatic dir_t bin_of(input logic [PHASE_W-1:0] ph);
    logic signed [PHASE_W:0] t;
    dir_t d;
    t = signed'({ph[PHASE_W-1], ph});
    if (t < 0) t = t + PI_Q12;
    priority if (t <= BOUND_1) d = DIR_HORIZONTAL;
    else if (t <= BOUND_2)     d = DIR_DIAG_DOWN_RIGHT;
    else if (t <= BOUND_3)     d = DIR_VERTICAL;
    else if (t <= BOUND_4)     d = DIR_DIAG_DOWN_LEFT;
    else                       d = DIR_HORIZONTAL;
    return d;
  endfunction

endpackage

// ===== sv/nms_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module nms_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/nms_cell.sv =====
// Window cell: one 3-pixel column register, loaded from its neighbor.
module nms_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  nms_pkg::column_t col_in,
  output nms_pkg::column_t col_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_out <= '0;
    end else if (shift) begin
      col_out <= col_in;
    end
  end

endmodule

// ===== sv/non_maximum_suppression.sv =====
// Latency: a pixel's result follows frame_width+1 further accepted items; it passes the window
//   stage register and then the output register before it shows on m_tvalid.
// Throughput: one pixel per clock unless m_tready stalls it (one RAM read and write per cycle).
// Reset: counters, window cells, held direction and output valid clear; frame size returns
//   to 1024x1024 (clamped to the maximum). Line buffers keep their contents, no clearing pass.
`include "non_maximum_suppression_defines.svh"

// Top level: counters, line buffer, window cell chain and suppression decision.
module non_maximum_suppression #(
  parameter int MAX_WIDTH  = nms_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = nms_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // s_tdata: magnitude[15:0], phase[30:16], zero fill
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [nms_pkg::S_TDATA_W-1:0]  s_tdata,
  // s_tuser: mode (1 = padding item)
  input  logic                           s_tuser,
  // m_tdata: kept_magnitude[15:0], direction_bin[17:16], zero fill
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [nms_pkg::M_TDATA_W-1:0]  m_tdata,
  // m_tlast: end_of_frame
  output logic                           m_tlast,
  input  logic                           cfg_wr_en,
  input  logic [0:0]                     cfg_index,
  input  logic [nms_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 3);
  localparam int W_RESET = (nms_pkg::FRAME_WIDTH_RESET > MAX_WIDTH) ?
                           MAX_WIDTH : nms_pkg::FRAME_WIDTH_RESET;
  localparam int H_RESET = (nms_pkg::FRAME_HEIGHT_RESET > MAX_HEIGHT) ?
                           MAX_HEIGHT : nms_pkg::FRAME_HEIGHT_RESET;

  typedef struct packed {
    logic colhi;  // column above zero: right column is live
    logic emit;   // step yields a result
    logic top;    // centre on first frame row
    logic bot;    // centre on last frame row
    logic lft;    // centre on first frame column
    logic eof;    // centre is last pixel of frame
  } ctrl_t;

  // ---------------- frame size and counters ----------------
  logic [WID_W-1:0] w_reg, w_cfg;
  logic [ROW_W-1:0] h_reg, h_cfg, h1;
  logic [COL_W-1:0] col_cnt, c_a;
  logic [ROW_W-1:0] row_cnt;
  logic             accept;
  ctrl_t            ctrl_a;
  logic             last_col;

  logic [nms_pkg::FRAME_WIDTH_W-1:0]  cfg_fw;
  logic [nms_pkg::FRAME_HEIGHT_W-1:0] cfg_fh;

  assign cfg_fw = cfg_wdata[nms_pkg::FRAME_WIDTH_W-1:0];
  assign cfg_fh = cfg_wdata[nms_pkg::FRAME_HEIGHT_W-1:0];

  // clamp register writes to 1..MAX
  always_comb begin
    if (cfg_fw == '0)                      w_cfg = WID_W'(1);
    else if (32'(cfg_fw) > 32'(MAX_WIDTH)) w_cfg = WID_W'(MAX_WIDTH);
    else                                   w_cfg = WID_W'(cfg_fw);
    if (cfg_fh == '0)                       h_cfg = ROW_W'(1);
    else if (32'(cfg_fh) > 32'(MAX_HEIGHT)) h_cfg = ROW_W'(MAX_HEIGHT);
    else                                    h_cfg = ROW_W'(cfg_fh);
  end

  assign h1 = h_reg + ROW_W'(1);

  // window position of the incoming item
  always_comb begin
    c_a = (WID_W'(col_cnt) >= w_reg) ? '0 : col_cnt;
    ctrl_a.colhi = (c_a != '0);
    if (ctrl_a.colhi) begin
      ctrl_a.emit = (row_cnt != '0) && (row_cnt <= h_reg);
      ctrl_a.top  = (row_cnt == ROW_W'(1));
      ctrl_a.bot  = (row_cnt >= h_reg);
      ctrl_a.lft  = (c_a == COL_W'(1));
    end else begin
      ctrl_a.emit = (row_cnt >= ROW_W'(2)) && (row_cnt <= h1);
      ctrl_a.top  = (row_cnt == ROW_W'(2));
      ctrl_a.bot  = (row_cnt >= h1);
      ctrl_a.lft  = (w_reg == WID_W'(1));
    end
    ctrl_a.eof = !ctrl_a.colhi && (row_cnt == h1);
    last_col   = (WID_W'(c_a) + WID_W'(1)) >= w_reg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_reg   <= WID_W'(W_RESET);
      h_reg   <= ROW_W'(H_RESET);
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (cfg_wr_en) begin
      unique case (nms_pkg::cfg_reg_t'(cfg_index))
        nms_pkg::CFG_FRAME_WIDTH:  w_reg <= w_cfg;
        nms_pkg::CFG_FRAME_HEIGHT: h_reg <= h_cfg;
        default: ;
      endcase
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (ctrl_a.eof) begin
        col_cnt <= '0;
        row_cnt <= '0;
      end else if (last_col) begin
        col_cnt <= '0;
        row_cnt <= (row_cnt <= h1) ? row_cnt + ROW_W'(1) : '0;
      end else begin
        col_cnt <= c_a + COL_W'(1);
      end
    end
  end

  // ---------------- window stage ----------------
  logic                          valid_b, b_adv;
  ctrl_t                         ctrl_b;
  nms_pkg::mag_t                 mag_b;
  logic [nms_pkg::PHASE_W-1:0]   ph_b;
  logic [COL_W-1:0]              c_b;
  logic                          fwd_b;
  nms_pkg::line_word_t           fwd_word_b, rd_word, word_b, wr_word;
  logic [nms_pkg::LINE_WORD_W-1:0] rd_bits;

  assign accept   = s_tvalid && s_tready;
  assign b_adv    = valid_b && (!ctrl_b.emit || !m_tvalid || m_tready);
  assign s_tready = !valid_b || b_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
      fwd_b   <= 1'b0;
    end else if (accept) begin
      valid_b <= 1'b1;
      // same-address write in this cycle: RAM returns the old word
      fwd_b   <= b_adv && (c_b == c_a);
    end else if (b_adv) begin
      valid_b <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctrl_b     <= ctrl_a;
      mag_b      <= s_tuser ? '0 : s_tdata[nms_pkg::MAG_W-1:0];
      ph_b       <= s_tuser ? '0 : s_tdata[nms_pkg::MAG_W +: nms_pkg::PHASE_W];
      c_b        <= c_a;
      fwd_word_b <= wr_word;
    end
  end

  assign rd_word = nms_pkg::line_word_t'(rd_bits);
  assign word_b  = fwd_b ? fwd_word_b : rd_word;

  // line buffer update: centre row moves up, new pixel becomes centre
  assign wr_word.upper  = word_b.centre;
  assign wr_word.centre = mag_b;
  assign wr_word.phase  = ph_b;

  nms_ram #(
    .DATA_W (nms_pkg::LINE_WORD_W),
    .DEPTH  (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (b_adv),
    .wr_addr (c_b),
    .wr_data (wr_word),
    .rd_en   (accept),
    .rd_addr (c_a),
    .rd_data (rd_bits)
  );

  // ---------------- window cell chain ----------------
  nms_pkg::column_t fresh, mid_col, left_col;

  assign fresh[0] = word_b.upper;
  assign fresh[1] = word_b.centre;
  assign fresh[2] = mag_b;

  nms_cell u_mid_cell (
    .clk     (clk),
    .rst     (rst),
    .shift   (b_adv),
    .col_in  (fresh),
    .col_out (mid_col)
  );

  nms_cell u_left_cell (
    .clk     (clk),
    .rst     (rst),
    .shift   (b_adv),
    .col_in  (mid_col),
    .col_out (left_col)
  );

  // direction of the current centre, from the phase stored one row ago
  nms_pkg::dir_t held_bin;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_bin <= nms_pkg::DIR_HORIZONTAL;
    end else if (b_adv) begin
      held_bin <= nms_pkg::bin_of(word_b.phase);
    end
  end

  // ---------------- suppression decision ----------------
  nms_pkg::column_t lf, md, rt;
  nms_pkg::mag_t    n1, n2, cen, kept;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lf[k] = ctrl_b.lft ? '0 : left_col[k];
      md[k] = mid_col[k];
      rt[k] = ctrl_b.colhi ? fresh[k] : '0;
    end
    if (ctrl_b.top) begin
      lf[0] = '0;
      md[0] = '0;
      rt[0] = '0;
    end
    if (ctrl_b.bot) begin
      lf[2] = '0;
      md[2] = '0;
      rt[2] = '0;
    end
    cen = md[1];
    unique case (held_bin)
      nms_pkg::DIR_DIAG_DOWN_RIGHT: begin
        n1 = lf[0];
        n2 = rt[2];
      end
      nms_pkg::DIR_VERTICAL: begin
        n1 = md[0];
        n2 = md[2];
      end
      nms_pkg::DIR_DIAG_DOWN_LEFT: begin
        n1 = rt[0];
        n2 = lf[2];
      end
      default: begin
        n1 = lf[1];
        n2 = rt[1];
      end
    endcase
    kept = ((n1 > cen) || (n2 > cen)) ? '0 : cen;
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (b_adv && ctrl_b.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && ctrl_b.emit) begin
      m_tdata <= nms_pkg::M_TDATA_W'({held_bin, kept});
      m_tlast <= ctrl_b.eof;
    end
  end

  // ---------------- assertions ----------------
  `NMS_ASSERT_IMPL(a_col_in_row, 1'b1, WID_W'(col_cnt) < w_reg, "column count past row width")
  `NMS_ASSERT_IMPL(a_row_bound, 1'b1, row_cnt <= h1 + ROW_W'(1), "row count past drain rows")
  `NMS_ASSERT_IMPL(a_eof_col0, valid_b && ctrl_b.eof, ctrl_b.emit && !ctrl_b.colhi, "frame end off column zero")
  `NMS_ASSERT_NEXT(a_eof_restart, accept && !cfg_wr_en && ctrl_a.eof, col_cnt == '0 && row_cnt == '0, "frame did not restart")

endmodule

// ===== sim/tb_non_maximum_suppression.sv =====
// Self-checking testbench for the non-maximum suppression stream block.
`timescale 1ns / 1ps

module tb_non_maximum_suppression;

  localparam int STALL_LIMIT   = 5000;
  localparam int RANDOM_ITEMS  = 400;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int DIRECTED_ROWS = 8;

  // One expected output transfer
  typedef struct packed {
    logic [nms_pkg::MAG_W-1:0] kept;
    nms_pkg::dir_t             bin;
    logic                      eof;
  } nms_result_t;

  // Directed row: one 1x1 frame, its pixel and the result it must give
  typedef struct packed {
    logic                        mode;
    logic [nms_pkg::MAG_W-1:0]   mag;
    logic [nms_pkg::PHASE_W-1:0] ph;
    logic [nms_pkg::MAG_W-1:0]   kept;
    nms_pkg::dir_t               bin;
  } frame_row_t;

  // A lone pixel has no neighbours inside the frame, so it is always kept
  localparam frame_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
    '{1'b0, 16'hFFFF, 15'd1608,    16'hFFFF, nms_pkg::DIR_HORIZONTAL},
    '{1'b0, 16'h0000, 15'd4825,    16'h0000, nms_pkg::DIR_DIAG_DOWN_RIGHT},
    '{1'b0, 16'h0001, 15'd8042,    16'h0001, nms_pkg::DIR_VERTICAL},
    '{1'b0, 16'h8000, 15'd11259,   16'h8000, nms_pkg::DIR_DIAG_DOWN_LEFT},
    '{1'b0, 16'h5555, 15'(-11259), 16'h5555, nms_pkg::DIR_DIAG_DOWN_RIGHT},
    '{1'b1, 16'hFFFF, 15'd8000,    16'h0000, nms_pkg::DIR_HORIZONTAL},
    '{1'b0, 16'hAAAA, 15'(-16384), 16'hAAAA, nms_pkg::DIR_HORIZONTAL},
    '{1'b0, 16'h1234, 15'd16383,   16'h1234, nms_pkg::DIR_HORIZONTAL}
  };

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [nms_pkg::S_TDATA_W-1:0]    s_tdata = '0;
  logic                             s_tuser = 1'b0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [nms_pkg::M_TDATA_W-1:0]    m_tdata;
  logic                             m_tlast;
  logic                             cfg_wr_en = 1'b0;
  logic [0:0]                       cfg_index = '0;
  logic [nms_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;

  // Predictor state
  logic [nms_pkg::MAG_W-1:0]          upper_rows [nms_pkg::MAX_WIDTH_DEF];
  logic [nms_pkg::MAG_W-1:0]          centre_rows [nms_pkg::MAX_WIDTH_DEF];
  logic [nms_pkg::PHASE_W-1:0]        centre_phases [nms_pkg::MAX_WIDTH_DEF];
  logic [nms_pkg::MAG_W-1:0]          window_cells [6];
  logic [nms_pkg::PHASE_W-1:0]        held_phase;
  int unsigned                        col_count;
  int unsigned                        row_count;
  logic [nms_pkg::FRAME_WIDTH_W-1:0]  width_setting;
  logic [nms_pkg::FRAME_HEIGHT_W-1:0] height_setting;

  nms_result_t             awaited_pixels [$];
  int                      error_count = 0;
  int                      items_sent = 0;
  int                      send_idle_pct = 0;
  int                      recv_idle_pct = 0;
  int                      hold_requests = 0;
  int                      holds_done = 0;
  int                      hold_left = 0;
  int                      quiet_cycles = 0;

  non_maximum_suppression DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int unsigned active_width();
    if (width_setting == 0) return 1;
    if (width_setting > nms_pkg::MAX_WIDTH_DEF) return nms_pkg::MAX_WIDTH_DEF;
    return width_setting;
  endfunction

  function automatic int unsigned active_height();
    if (height_setting == 0) return 1;
    if (height_setting > nms_pkg::MAX_HEIGHT_DEF) return nms_pkg::MAX_HEIGHT_DEF;
    return height_setting;
  endfunction

  // Fold by pi, then bin against pi/8 .. 7pi/8
  function automatic nms_pkg::dir_t direction_of(logic [nms_pkg::PHASE_W-1:0] ph);
    int t;
    t = int'($signed(ph));
    if (t < 0) t = t + int'(nms_pkg::PI_Q12);
    if (t <= int'(nms_pkg::BOUND_1)) return nms_pkg::DIR_HORIZONTAL;
    if (t <= int'(nms_pkg::BOUND_2)) return nms_pkg::DIR_DIAG_DOWN_RIGHT;
    if (t <= int'(nms_pkg::BOUND_3)) return nms_pkg::DIR_VERTICAL;
    if (t <= int'(nms_pkg::BOUND_4)) return nms_pkg::DIR_DIAG_DOWN_LEFT;
    return nms_pkg::DIR_HORIZONTAL;
  endfunction

  task automatic clear_predictor();
    for (int i = 0; i < nms_pkg::MAX_WIDTH_DEF; i++) begin
      upper_rows[i] = '0;
      centre_rows[i] = '0;
      centre_phases[i] = '0;
    end
    for (int i = 0; i < 6; i++) window_cells[i] = '0;
    held_phase = '0;
    col_count = 0;
    row_count = 0;
    width_setting = nms_pkg::FRAME_WIDTH_W'(nms_pkg::FRAME_WIDTH_RESET);
    height_setting = nms_pkg::FRAME_HEIGHT_W'(nms_pkg::FRAME_HEIGHT_RESET);
  endtask

  // Advance the window by one pixel and work out the result it releases
  task automatic suppress_pixel(input logic mode, input logic [nms_pkg::MAG_W-1:0] mag_in,
                                input logic [nms_pkg::PHASE_W-1:0] ph_in, output bit emits,
                                output nms_result_t res);
    int unsigned                 w, h, c, r, a, b;
    logic [nms_pkg::MAG_W-1:0]   mag, n1, n2, centre;
    logic [nms_pkg::MAG_W-1:0]   fresh [3];
    logic [nms_pkg::MAG_W-1:0]   lf [3];
    logic [nms_pkg::MAG_W-1:0]   md [3];
    logic [nms_pkg::MAG_W-1:0]   rt [3];
    logic [nms_pkg::PHASE_W-1:0] ph;
    nms_pkg::dir_t               dir;
    bit                          eof;
    w = active_width();
    h = active_height();
    mag = mag_in;
    ph = ph_in;
    if (mode) begin
      mag = '0;
      ph = '0;
    end
    c = col_count;
    r = row_count;
    if (c >= w) c = 0;
    fresh[0] = upper_rows[c];
    fresh[1] = centre_rows[c];
    fresh[2] = mag;
    emits = 1'b0;
    eof = 1'b0;
    a = 0;
    b = 0;
    res = '0;
    if (c >= 1) begin
      if (r >= 1 && r <= h) begin
        emits = 1'b1;
        a = r - 1;
        b = c - 1;
      end
    end else if (r >= 2 && r <= h + 1) begin
      emits = 1'b1;
      a = r - 2;
      b = w - 1;
    end

    if (emits) begin
      for (int k = 0; k < 3; k++) begin
        lf[k] = (b == 0) ? '0 : window_cells[k];
        md[k] = window_cells[3 + k];
        rt[k] = (c >= 1) ? fresh[k] : '0;
      end
      // top and bottom rows of the frame see zero outside
      if (a == 0) begin
        lf[0] = '0;
        md[0] = '0;
        rt[0] = '0;
      end
      if (a + 1 >= h) begin
        lf[2] = '0;
        md[2] = '0;
        rt[2] = '0;
      end
      centre = md[1];
      dir = direction_of(held_phase);
      case (dir)
        nms_pkg::DIR_DIAG_DOWN_RIGHT: begin
          n1 = lf[0];
          n2 = rt[2];
        end
        nms_pkg::DIR_VERTICAL: begin
          n1 = md[0];
          n2 = md[2];
        end
        nms_pkg::DIR_DIAG_DOWN_LEFT: begin
          n1 = rt[0];
          n2 = lf[2];
        end
        default: begin
          n1 = lf[1];
          n2 = rt[1];
        end
      endcase
      eof = (a == h - 1) && (b == w - 1);
      res.kept = (n1 > centre || n2 > centre) ? '0 : centre;
      res.bin = dir;
      res.eof = eof;
    end

    // shift window, rotate line buffers
    window_cells[0] = window_cells[3];
    window_cells[1] = window_cells[4];
    window_cells[2] = window_cells[5];
    window_cells[3] = fresh[0];
    window_cells[4] = fresh[1];
    window_cells[5] = fresh[2];
    held_phase = centre_phases[c];
    centre_phases[c] = ph;
    upper_rows[c] = centre_rows[c];
    centre_rows[c] = mag;

    if (eof) begin
      col_count = 0;
      row_count = 0;
    end else if (c + 1 >= w) begin
      col_count = 0;
      row_count = (r <= h + 1) ? r + 1 : 0;
    end else begin
      col_count = c + 1;
      row_count = r;
    end
  endtask

  // Mix ties, small values and full-range values so suppression is exercised
  function automatic logic [nms_pkg::MAG_W-1:0] random_magnitude();
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) return nms_pkg::MAG_W'($urandom_range(3));
    if (pick < 35) return '1;
    return nms_pkg::MAG_W'($urandom_range(65535));
  endfunction

  function automatic logic [nms_pkg::PHASE_W-1:0] random_phase();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      case ($urandom_range(13))
        0: return 15'd1608;
        1: return 15'd1609;
        2: return 15'd4825;
        3: return 15'd4826;
        4: return 15'd8042;
        5: return 15'd8043;
        6: return 15'd11259;
        7: return 15'd11260;
        8: return 15'(-12868);
        9: return 15'(-11260);
        10: return 15'(-11259);
        11: return 15'(-1);
        12: return 15'd0;
        default: return 15'd12868;
      endcase
    end
    if (pick < 25) return nms_pkg::PHASE_W'($urandom_range(32767));
    return nms_pkg::PHASE_W'(int'($urandom_range(25736)) - 12868);
  endfunction

  // Offer one pixel, wait for its transfer, then record what it releases
  task automatic send_item(input logic mode, input logic [nms_pkg::MAG_W-1:0] mag,
                           input logic [nms_pkg::PHASE_W-1:0] ph, input bit typed = 1'b0,
                           input nms_result_t typed_res = '0);
    bit          emits;
    nms_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {1'b0, ph, mag};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    suppress_pixel(mode, mag, ph, emits, res);
    if (typed) awaited_pixels.push_back(typed_res);
    else if (emits) awaited_pixels.push_back(res);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_pixel();
    send_item($urandom_range(9) == 0, random_magnitude(), random_phase());
  endtask

  // Stop offering and wait until every pending result has come out
  task automatic settle();
    s_tvalid <= 1'b0;
    while (awaited_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input nms_pkg::cfg_reg_t idx,
                                input logic [nms_pkg::CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == nms_pkg::CFG_FRAME_WIDTH) width_setting = value[nms_pkg::FRAME_WIDTH_W-1:0];
    else height_setting = value[nms_pkg::FRAME_HEIGHT_W-1:0];
    col_count = 0;
    row_count = 0;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [nms_pkg::CFG_DATA_W-1:0] w,
                           input logic [nms_pkg::CFG_DATA_W-1:0] h);
    settle();
    write_register(nms_pkg::CFG_FRAME_WIDTH, w);
    write_register(nms_pkg::CFG_FRAME_HEIGHT, h);
  endtask

  // Full frame of random pixels plus the padding that drains it
  task automatic run_frame();
    int unsigned w, h;
    w = active_width();
    h = active_height();
    repeat (w * h) send_random_pixel();
    // drain: mostly padding, some real pixels past the last row
    repeat (w + 1) send_item($urandom_range(6) != 0, random_magnitude(), random_phase());
  endtask

  function automatic logic [nms_pkg::CFG_DATA_W-1:0] random_width();
    if ($urandom_range(4) == 0) return nms_pkg::CFG_DATA_W'($urandom_range(40, 9));
    return nms_pkg::CFG_DATA_W'($urandom_range(8, 1));
  endfunction

  function automatic logic [nms_pkg::CFG_DATA_W-1:0] random_height();
    return nms_pkg::CFG_DATA_W'($urandom_range(6, 1));
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      error_count++;
      if (error_count <= 10)
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
    end
  endtask

  // Receiver: random back-pressure, plus one long hold on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_done) begin
      m_tready <= 1'b0;
      holds_done <= holds_done + 1;
      hold_left <= LONG_HOLD;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Output checker: each transfer against the oldest pending result
  always @(posedge clk) begin : collect
    nms_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_pixels.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: output transfer with no result pending: kept %0d bin %0d last %0b",
                   $realtime, m_tdata[15:0], m_tdata[17:16], m_tlast);
      end else begin
        want = awaited_pixels.pop_front();
        check_field("kept_magnitude", want.kept, m_tdata[15:0]);
        check_field("direction_bin", want.bin, m_tdata[17:16]);
        check_field("end_of_frame", want.eof, m_tlast);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_non_maximum_suppression: errors");
      $finish;
    end
  end

  initial begin
    nms_result_t typed;
    int          random_start;
    int          choice;
    bit          stall_tested;
    stall_tested = 1'b0;
    clear_predictor();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: 1x1 frames, pixel then two padding items that drain it
    configure(13'd1, 13'd1);
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      typed.kept = DIRECTED_TABLE[i].kept;
      typed.bin = DIRECTED_TABLE[i].bin;
      typed.eof = 1'b1;
      send_item(DIRECTED_TABLE[i].mode, DIRECTED_TABLE[i].mag, DIRECTED_TABLE[i].ph);
      send_item(1'b1, 16'hFFFF, 15'h7FFF);
      send_item(1'b1, 16'hFFFF, 15'h7FFF, 1'b1, typed);
    end

    // Out-of-range settings: zero acts as one, upper width bits are dropped
    send_idle_pct = 16;
    recv_idle_pct = 81;
    configure(13'd0, 13'd0);
    run_frame();
    // upper bits of the width write fall outside the register
    configure(13'h1803, 13'd3);
    run_frame();

    // Random frames across three idling phases
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if (items_sent - random_start < RANDOM_ITEMS / 3) begin
        send_idle_pct = 16;
        recv_idle_pct = 81;
      end else if (items_sent - random_start < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 81;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      if (send_idle_pct == 0 && !stall_tested) begin
        // long output hold while input keeps coming: block must back up
        stall_tested = 1'b1;
        configure(13'd8, 13'd6);
        hold_requests++;
      end else begin
        choice = $urandom_range(99);
        if (choice < 10) begin
          // aborted frame: some or all of row 0, then a register write restarts it
          repeat ($urandom_range(active_width(), 1)) send_random_pixel();
          configure(random_width(), random_height());
        end else if (choice < 60) begin
          configure(random_width(), random_height());
        end else if (choice < 85) begin
          settle();
          if ($urandom_range(1)) write_register(nms_pkg::CFG_FRAME_WIDTH, random_width());
          else write_register(nms_pkg::CFG_FRAME_HEIGHT, random_height());
        end
        // otherwise the next frame follows back to back
      end
      run_frame();
    end

    // Drain and report
    s_tvalid <= 1'b0;
    while (awaited_pixels.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("tb_non_maximum_suppression: clean");
    end else begin
      $display("tb_non_maximum_suppression: errors");
    end
    $finish;
  end

endmodule
